// ===== design/slcf_pkg.sv =====
// ----------------------------------------------------------------------------
// Safety link connection FSM package
// Code enumerations, the fixed transition table and the decoded result type
// shared by the rule decoder and the core.
// ----------------------------------------------------------------------------
package slcf_pkg;

  // Width of the internal action lists; only the first ReportSlots are reported.
  localparam int unsigned ActionSlots = 4;
  localparam int unsigned ReportSlots = 4;
  localparam int unsigned NumRules    = 27;
  localparam logic [4:0]  NumEvents   = 5'd18;

  typedef enum logic [2:0] {
    ST_UNINIT      = 3'd0,
    ST_INIT        = 3'd1,
    ST_CONNECTING  = 3'd2,
    ST_ESTABLISHED = 3'd3,
    ST_RETX        = 3'd4,
    ST_SAFE_DISC   = 3'd5,
    ST_SHUTDOWN    = 3'd6,
    ST_INVALID     = 3'd7
  } state_e;

  typedef enum logic [4:0] {
    EV_INIT_SUCCESS     = 5'd0,
    EV_INIT_FAILURE     = 5'd1,
    EV_SHUTDOWN_REQ     = 5'd2,
    EV_CONNECT_REQ      = 5'd3,
    EV_INBOUND_CONNECT  = 5'd4,
    EV_HANDSHAKE_OK     = 5'd5,
    EV_HEARTBEAT        = 5'd6,
    EV_TIMEOUT          = 5'd7,
    EV_INVALID_MSG      = 5'd8,
    EV_VERSION_MISMATCH = 5'd9,
    EV_VALID_DATA       = 5'd10,
    EV_SEQ_GAP          = 5'd11,
    EV_DISCONNECT_REQ   = 5'd12,
    EV_PROTOCOL_ERROR   = 5'd13,
    EV_RECOVERY_OK      = 5'd14,
    EV_RETX_FAILURE     = 5'd15,
    EV_INVALID_RESP     = 5'd16,
    EV_CLEANUP_DONE     = 5'd17
  } event_e;

  typedef enum logic [1:0] {
    OC_OK            = 2'd0,
    OC_REJECTED      = 2'd1,
    OC_INVALID_STATE = 2'd2,
    OC_INVALID_EVENT = 2'd3
  } outcome_e;

  typedef enum logic [4:0] {
    RS_NONE               = 5'd0,
    RS_INIT_COMPLETED     = 5'd1,
    RS_INIT_FAILED        = 5'd2,
    RS_SHUTDOWN_REQ       = 5'd3,
    RS_CONNECT_REQ        = 5'd4,
    RS_INBOUND_ACCEPTED   = 5'd5,
    RS_HANDSHAKE_DONE     = 5'd6,
    RS_HEARTBEAT_OK       = 5'd7,
    RS_TIMEOUT_EXPIRED    = 5'd8,
    RS_INVALID_MSG        = 5'd9,
    RS_VERSION_MISMATCH   = 5'd10,
    RS_DATA_ACCEPTED      = 5'd11,
    RS_SEQ_GAP            = 5'd12,
    RS_DISCONNECT_REQ     = 5'd13,
    RS_PROTOCOL_ERROR     = 5'd14,
    RS_RECOVERY_DONE      = 5'd15,
    RS_RETX_FAILED        = 5'd16,
    RS_INVALID_RESP       = 5'd17,
    RS_CLEANUP_DONE       = 5'd18,
    RS_UNEXPECTED_REJECT  = 5'd19,
    RS_FAILSAFE           = 5'd20,
    RS_IGNORED_SAFE_DISC  = 5'd21,
    RS_INVALID_STATE      = 5'd22,
    RS_INVALID_EVENT      = 5'd23,
    RS_IGNORED_SHUTDOWN   = 5'd24
  } reason_e;

  typedef enum logic [3:0] {
    DG_NONE           = 4'd0,
    DG_INFO_TRANSIT   = 4'd1,
    DG_ERR_CONFIG     = 4'd2,
    DG_INFO_OPER      = 4'd3,
    DG_ERR_TIMEOUT    = 4'd4,
    DG_ERR_PROTOCOL   = 4'd5,
    DG_WARN_REJECTED  = 4'd6,
    DG_WARN_IGNORED   = 4'd7,
    DG_ERR_INTERNAL   = 4'd8,
    DG_ERR_INTERFACE  = 4'd9
  } diag_e;

  typedef enum logic [3:0] {
    AC_NONE          = 4'd0,
    AC_LOG_DIAG      = 4'd1,
    AC_NOTIFY_API    = 4'd2,
    AC_SEND_DISC     = 4'd3,
    AC_ENTER_FAILSAFE = 4'd4,
    AC_FINAL_SHUTDOWN = 4'd5,
    AC_START_HS      = 4'd6,
    AC_START_SUP     = 4'd7,
    AC_ACCEPT_INBOUND = 4'd8,
    AC_RESET_SUP     = 4'd9,
    AC_RELEASE_RES   = 4'd10,
    AC_DELIVER_DATA  = 4'd11,
    AC_REQ_RETX      = 4'd12,
    AC_CLEAR_RETX    = 4'd13
  } action_e;

  typedef action_e [0:ActionSlots-1] act_list_t;
  typedef action_e [0:ReportSlots-1] act_report_t;

  typedef struct packed {
    state_e     from_st;
    event_e     ev;
    state_e     next_st;
    outcome_e   outcome;
    reason_e    reason;
    diag_e      diag;
    logic [2:0] count;
    act_list_t  acts;
  } rule_t;

  // Decoded result of one event, handed from the decoder to the core.
  typedef struct packed {
    state_e      prior_st;
    state_e      next_st;
    outcome_e    outcome;
    reason_e     reason;
    diag_e       diag;
    logic [2:0]  count;
    act_report_t acts;
    logic        count_event;
  } result_t;

  // Builds an action list from four leading codes; any further slots are none.
  function automatic act_list_t acts4(action_e a0, action_e a1, action_e a2,
                                      action_e a3);
    act_list_t lst;
    for (int unsigned i = 0; i < ActionSlots; i++) begin
      lst[i] = AC_NONE;
    end
    lst[0] = a0;
    lst[1] = a1;
    lst[2] = a2;
    lst[3] = a3;
    return lst;
  endfunction

  function automatic rule_t mk(state_e f, event_e e, state_e n, outcome_e o,
                               reason_e r, diag_e d, logic [2:0] c,
                               act_list_t a);
    rule_t rl;
    rl.from_st = f;
    rl.ev      = e;
    rl.next_st = n;
    rl.outcome = o;
    rl.reason  = r;
    rl.diag    = d;
    rl.count   = c;
    rl.acts    = a;
    return rl;
  endfunction

  localparam act_list_t ActsNone     = acts4(AC_NONE, AC_NONE, AC_NONE, AC_NONE);
  localparam act_list_t ActsFailsafe = acts4(AC_SEND_DISC, AC_ENTER_FAILSAFE,
                                             AC_NOTIFY_API, AC_LOG_DIAG);
  localparam act_list_t ActsReject   = acts4(AC_LOG_DIAG, AC_NOTIFY_API,
                                             AC_NONE, AC_NONE);
  localparam act_list_t ActsIgnore   = acts4(AC_LOG_DIAG, AC_NONE, AC_NONE, AC_NONE);
  localparam act_list_t ActsShutdown = acts4(AC_SEND_DISC, AC_RELEASE_RES,
                                             AC_FINAL_SHUTDOWN, AC_NOTIFY_API);

  // Fixed transition table: (from, event) -> next, outcome, reason, diag, actions.
  localparam rule_t Rules [NumRules] = '{
    mk(ST_UNINIT, EV_INIT_SUCCESS, ST_INIT, OC_OK, RS_INIT_COMPLETED,
       DG_INFO_TRANSIT, 3'd2, acts4(AC_LOG_DIAG, AC_NOTIFY_API, AC_NONE, AC_NONE)),
    mk(ST_UNINIT, EV_INIT_FAILURE, ST_SHUTDOWN, OC_REJECTED, RS_INIT_FAILED,
       DG_ERR_CONFIG, 3'd3,
       acts4(AC_LOG_DIAG, AC_FINAL_SHUTDOWN, AC_NOTIFY_API, AC_NONE)),
    mk(ST_UNINIT, EV_SHUTDOWN_REQ, ST_SHUTDOWN, OC_OK, RS_SHUTDOWN_REQ,
       DG_INFO_TRANSIT, 3'd1, acts4(AC_FINAL_SHUTDOWN, AC_NONE, AC_NONE, AC_NONE)),
    mk(ST_INIT, EV_CONNECT_REQ, ST_CONNECTING, OC_OK, RS_CONNECT_REQ,
       DG_INFO_TRANSIT, 3'd3,
       acts4(AC_START_HS, AC_START_SUP, AC_NOTIFY_API, AC_NONE)),
    mk(ST_INIT, EV_INBOUND_CONNECT, ST_CONNECTING, OC_OK, RS_INBOUND_ACCEPTED,
       DG_INFO_TRANSIT, 3'd3,
       acts4(AC_ACCEPT_INBOUND, AC_START_SUP, AC_NOTIFY_API, AC_NONE)),
    mk(ST_INIT, EV_SHUTDOWN_REQ, ST_SHUTDOWN, OC_OK, RS_SHUTDOWN_REQ,
       DG_INFO_TRANSIT, 3'd2,
       acts4(AC_FINAL_SHUTDOWN, AC_NOTIFY_API, AC_NONE, AC_NONE)),
    mk(ST_CONNECTING, EV_HANDSHAKE_OK, ST_ESTABLISHED, OC_OK, RS_HANDSHAKE_DONE,
       DG_INFO_TRANSIT, 3'd3,
       acts4(AC_RESET_SUP, AC_NOTIFY_API, AC_LOG_DIAG, AC_NONE)),
    mk(ST_CONNECTING, EV_HEARTBEAT, ST_CONNECTING, OC_OK, RS_HEARTBEAT_OK,
       DG_INFO_OPER, 3'd2, acts4(AC_RESET_SUP, AC_LOG_DIAG, AC_NONE, AC_NONE)),
    mk(ST_CONNECTING, EV_TIMEOUT, ST_SAFE_DISC, OC_REJECTED, RS_TIMEOUT_EXPIRED,
       DG_ERR_TIMEOUT, 3'd4, ActsFailsafe),
    mk(ST_CONNECTING, EV_INVALID_MSG, ST_SAFE_DISC, OC_REJECTED, RS_INVALID_MSG,
       DG_ERR_PROTOCOL, 3'd4, ActsFailsafe),
    mk(ST_CONNECTING, EV_VERSION_MISMATCH, ST_SAFE_DISC, OC_REJECTED,
       RS_VERSION_MISMATCH, DG_ERR_PROTOCOL, 3'd4, ActsFailsafe),
    mk(ST_CONNECTING, EV_SHUTDOWN_REQ, ST_SHUTDOWN, OC_OK, RS_SHUTDOWN_REQ,
       DG_INFO_TRANSIT, 3'd4, ActsShutdown),
    mk(ST_ESTABLISHED, EV_HEARTBEAT, ST_ESTABLISHED, OC_OK, RS_HEARTBEAT_OK,
       DG_INFO_OPER, 3'd2, acts4(AC_RESET_SUP, AC_LOG_DIAG, AC_NONE, AC_NONE)),
    mk(ST_ESTABLISHED, EV_VALID_DATA, ST_ESTABLISHED, OC_OK, RS_DATA_ACCEPTED,
       DG_INFO_OPER, 3'd3,
       acts4(AC_RESET_SUP, AC_DELIVER_DATA, AC_LOG_DIAG, AC_NONE)),
    mk(ST_ESTABLISHED, EV_SEQ_GAP, ST_RETX, OC_OK, RS_SEQ_GAP,
       DG_INFO_TRANSIT, 3'd3,
       acts4(AC_REQ_RETX, AC_NOTIFY_API, AC_LOG_DIAG, AC_NONE)),
    mk(ST_ESTABLISHED, EV_DISCONNECT_REQ, ST_SAFE_DISC, OC_OK, RS_DISCONNECT_REQ,
       DG_INFO_TRANSIT, 3'd3,
       acts4(AC_SEND_DISC, AC_ENTER_FAILSAFE, AC_NOTIFY_API, AC_NONE)),
    mk(ST_ESTABLISHED, EV_TIMEOUT, ST_SAFE_DISC, OC_REJECTED, RS_TIMEOUT_EXPIRED,
       DG_ERR_TIMEOUT, 3'd4, ActsFailsafe),
    mk(ST_ESTABLISHED, EV_PROTOCOL_ERROR, ST_SAFE_DISC, OC_REJECTED,
       RS_PROTOCOL_ERROR, DG_ERR_PROTOCOL, 3'd4, ActsFailsafe),
    mk(ST_ESTABLISHED, EV_SHUTDOWN_REQ, ST_SHUTDOWN, OC_OK, RS_SHUTDOWN_REQ,
       DG_INFO_TRANSIT, 3'd4, ActsShutdown),
    mk(ST_RETX, EV_RECOVERY_OK, ST_ESTABLISHED, OC_OK, RS_RECOVERY_DONE,
       DG_INFO_TRANSIT, 3'd4,
       acts4(AC_CLEAR_RETX, AC_RESET_SUP, AC_NOTIFY_API, AC_LOG_DIAG)),
    mk(ST_RETX, EV_HEARTBEAT, ST_RETX, OC_OK, RS_HEARTBEAT_OK,
       DG_INFO_OPER, 3'd2, acts4(AC_RESET_SUP, AC_LOG_DIAG, AC_NONE, AC_NONE)),
    mk(ST_RETX, EV_RETX_FAILURE, ST_SAFE_DISC, OC_REJECTED, RS_RETX_FAILED,
       DG_ERR_PROTOCOL, 3'd4, ActsFailsafe),
    mk(ST_RETX, EV_INVALID_RESP, ST_SAFE_DISC, OC_REJECTED, RS_INVALID_RESP,
       DG_ERR_PROTOCOL, 3'd4, ActsFailsafe),
    mk(ST_RETX, EV_TIMEOUT, ST_SAFE_DISC, OC_REJECTED, RS_TIMEOUT_EXPIRED,
       DG_ERR_TIMEOUT, 3'd4, ActsFailsafe),
    mk(ST_RETX, EV_SHUTDOWN_REQ, ST_SHUTDOWN, OC_OK, RS_SHUTDOWN_REQ,
       DG_INFO_TRANSIT, 3'd4, ActsShutdown),
    mk(ST_SAFE_DISC, EV_CLEANUP_DONE, ST_INIT, OC_OK, RS_CLEANUP_DONE,
       DG_INFO_TRANSIT, 3'd3,
       acts4(AC_RELEASE_RES, AC_NOTIFY_API, AC_LOG_DIAG, AC_NONE)),
    mk(ST_SAFE_DISC, EV_SHUTDOWN_REQ, ST_SHUTDOWN, OC_OK, RS_SHUTDOWN_REQ,
       DG_INFO_TRANSIT, 3'd3,
       acts4(AC_RELEASE_RES, AC_FINAL_SHUTDOWN, AC_NOTIFY_API, AC_NONE))
  };

endpackage

// ===== design/slcf_rule_decode.sv =====
// ----------------------------------------------------------------------------
// Safety link connection FSM rule decoder
// Combinational lookup of one event against the transition table, with the
// invalid-state, invalid-event, shutdown and unmatched-event policies.
// ----------------------------------------------------------------------------
module slcf_rule_decode (
  input  slcf_pkg::state_e  state_i,
  input  logic [4:0]        event_i,
  output slcf_pkg::result_t res_o
);

  logic            hit;
  slcf_pkg::rule_t rule;
  slcf_pkg::result_t res;

  // Table search: the (from, event) pairs are unique, so at most one matches.
  always_comb begin
    hit  = 1'b0;
    rule = slcf_pkg::Rules[0];
    for (int unsigned i = 0; i < slcf_pkg::NumRules; i++) begin
      if (!hit && slcf_pkg::Rules[i].from_st == state_i &&
          slcf_pkg::Rules[i].ev == event_i) begin
        hit  = 1'b1;
        rule = slcf_pkg::Rules[i];
      end
    end
  end

  // Policy selection in priority order.
  always_comb begin
    res.prior_st    = state_i;
    res.next_st     = state_i;
    res.outcome     = slcf_pkg::OC_OK;
    res.reason      = slcf_pkg::RS_NONE;
    res.diag        = slcf_pkg::DG_NONE;
    res.count       = 3'd0;
    res.count_event = 1'b1;
    for (int unsigned i = 0; i < slcf_pkg::ReportSlots; i++) begin
      res.acts[i] = slcf_pkg::AC_NONE;
    end

    if (state_i == slcf_pkg::ST_INVALID) begin
      res.outcome     = slcf_pkg::OC_INVALID_STATE;
      res.reason      = slcf_pkg::RS_INVALID_STATE;
      res.diag        = slcf_pkg::DG_ERR_INTERNAL;
      res.count_event = 1'b0;
    end else if (event_i >= slcf_pkg::NumEvents) begin
      res.outcome     = slcf_pkg::OC_INVALID_EVENT;
      res.reason      = slcf_pkg::RS_INVALID_EVENT;
      res.diag        = slcf_pkg::DG_ERR_INTERFACE;
      res.count_event = 1'b0;
    end else if (state_i == slcf_pkg::ST_SHUTDOWN) begin
      res.reason = slcf_pkg::RS_IGNORED_SHUTDOWN;
      res.diag   = slcf_pkg::DG_WARN_IGNORED;
    end else if (hit) begin
      res.next_st = rule.next_st;
      res.outcome = rule.outcome;
      res.reason  = rule.reason;
      res.diag    = rule.diag;
      res.count   = rule.count;
      for (int unsigned i = 0; i < slcf_pkg::ReportSlots; i++) begin
        res.acts[i] = rule.acts[i];
      end
    end else if (state_i == slcf_pkg::ST_CONNECTING ||
                 state_i == slcf_pkg::ST_ESTABLISHED ||
                 state_i == slcf_pkg::ST_RETX) begin
      res.next_st = slcf_pkg::ST_SAFE_DISC;
      res.outcome = slcf_pkg::OC_REJECTED;
      res.reason  = slcf_pkg::RS_FAILSAFE;
      res.diag    = slcf_pkg::DG_ERR_PROTOCOL;
      res.count   = 3'd4;
      for (int unsigned i = 0; i < slcf_pkg::ReportSlots; i++) begin
        res.acts[i] = slcf_pkg::ActsFailsafe[i];
      end
    end else if (state_i == slcf_pkg::ST_SAFE_DISC) begin
      res.reason = slcf_pkg::RS_IGNORED_SAFE_DISC;
      res.diag   = slcf_pkg::DG_WARN_IGNORED;
      res.count  = 3'd1;
      for (int unsigned i = 0; i < slcf_pkg::ReportSlots; i++) begin
        res.acts[i] = slcf_pkg::ActsIgnore[i];
      end
    end else begin
      res.outcome = slcf_pkg::OC_REJECTED;
      res.reason  = slcf_pkg::RS_UNEXPECTED_REJECT;
      res.diag    = slcf_pkg::DG_WARN_REJECTED;
      res.count   = 3'd2;
      for (int unsigned i = 0; i < slcf_pkg::ReportSlots; i++) begin
        res.acts[i] = slcf_pkg::ActsReject[i];
      end
    end
  end

  // Slots at or beyond the action count are reported as none.
  always_comb begin
    res_o = res;
    for (int unsigned i = 0; i < slcf_pkg::ReportSlots; i++) begin
      if (3'(i) >= res.count) begin
        res_o.acts[i] = slcf_pkg::AC_NONE;
      end
    end
  end

endmodule

// ===== design/safety_link_connection_fsm_core.sv =====
// ----------------------------------------------------------------------------
// Safety link connection FSM core
// Keeps the link state and valid-event tally and reports one result per event.
// ----------------------------------------------------------------------------
// An accepted event's result is in the output register in the next cycle.
// Throughput: one event per cycle if not stalled; state and tally update in step.
// The output register takes a new result while the held one is being taken.
// Reset clears the link state to uninitialized, the tally to zero and the
// output valid flag.
module safety_link_connection_fsm_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [4:0] event_code, [7:5] zero
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // [2:0] prior_state, [5:3] new_state, [7:6] outcome, [12:8] reason_code,
  // [16:13] diagnostic_code, [19:17] action_count, [23:20] action_first,
  // [27:24] action_second, [31:28] action_third, [35:32] action_fourth,
  // [67:36] valid_event_total, [71:68] zero
  output logic [71:0] m_axis_tdata_o
);

  slcf_pkg::state_e  state_q, state_d;
  logic [31:0]       tally_q, tally_d;
  logic              out_valid_q;
  slcf_pkg::result_t out_res_q;
  logic [31:0]       out_total_q;
  slcf_pkg::result_t res;
  logic              accept;

  slcf_rule_decode u_decode (
    .state_i (state_q),
    .event_i (s_axis_tdata_i[4:0]),
    .res_o   (res)
  );

  // A new request is taken whenever the output register is empty or draining.
  assign s_axis_tready_o = !out_valid_q || m_axis_tready_i;
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;

  // Next link state and tally for the accepted event.
  always_comb begin
    state_d = state_q;
    tally_d = tally_q;
    if (accept) begin
      state_d = res.next_st;
      if (res.count_event) begin
        tally_d = tally_q + 32'd1;
      end
    end
  end

  // Control state and output valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= slcf_pkg::ST_UNINIT;
      tally_q     <= 32'd0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      tally_q <= tally_d;
      if (accept) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Result payload register.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_res_q   <= res;
      out_total_q <= tally_d;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {4'b0000, out_total_q,
                            out_res_q.acts[3], out_res_q.acts[2],
                            out_res_q.acts[1], out_res_q.acts[0],
                            out_res_q.count, out_res_q.diag, out_res_q.reason,
                            out_res_q.outcome, out_res_q.next_st,
                            out_res_q.prior_st};

endmodule
